[hw/rtl/md5_byte_stream_hasher_unit_defines.svh]
// Assertion macros used by the checker file of the MD5 byte stream hasher.
// Needs a clock named clk and an active high reset named rst in scope.
`ifndef MD5_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define MD5_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Same-cycle implication, muted while reset is high.
`define MD5BSH_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, muted while reset is high.
`define MD5BSH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/md5bsh_pkg.sv]
// Package of the MD5 byte stream hasher: codes, state type, MD5 tables and
// the round function. Used by the top level and the bench.
package md5bsh_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_FIRST_POS = 6'd56;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [6:0] ROUND_END = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FOLD,
    ST_FIN
  } hash_state_t;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by a round.
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = i4;
      2'd1: g = 4'(i4 * 4'd5 + 4'd1);
      2'd2: g = 4'(i4 * 4'd3 + 4'd5);
      default: g = 4'(i4 * 4'd7);
    endcase
    return g;
  endfunction

  // New b word of one MD5 round.
  function automatic logic [31:0] md5_round(
    input logic [31:0] a,
    input logic [31:0] b,
    input logic [31:0] c,
    input logic [31:0] d,
    input logic [31:0] w,
    input logic [5:0]  rnd
  );
    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] dbl;
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + w + ROUND_K[rnd];
    dbl = {sum, sum} << ROT_AMT[{rnd[5:4], rnd[1:0]}];
    return dbl[63:32] + b;
  endfunction

endpackage

[hw/rtl/md5bsh_if.sv]
// Valid/ready channel interfaces of the MD5 byte stream hasher.
// Standalone; no package needed.
interface md5bsh_byte_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink (input valid, input command, input data_byte, output ready);
endinterface

interface md5bsh_digest_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_part;
  logic        part_index;
  logic        last_part;

  modport source (output valid, output digest_part, output part_index, output last_part,
                  input ready);
  modport sink (input valid, input digest_part, input part_index, input last_part,
                output ready);
endinterface

[hw/rtl/md5_byte_stream_hasher_unit.sv]
// Streaming MD5 hasher: absorbs message bytes, pads on finish, emits the digest.
// Depends on md5bsh_pkg and the channel interfaces in md5bsh_if.sv.
//
// Each word on msg carries a command: absorb (store data_byte) or finish (pad
// the message and produce its digest). When a byte completes a 64-byte
// block, the block is compressed: a step to prime the buffer read, 64 rounds
// at one round per cycle, and a step to fold the result into the chain value.
// New bytes are not accepted while a block is compressed, since intake and
// the round engine share the one block buffer memory. A finish writes the
// padding one byte per cycle from the fill position to the end of the block,
// compresses, and when fewer than 9 bytes of room remained it pads and
// compresses a second block. It then waits for any previous digest to leave.
// The digest leaves on the digest channel as two 64-bit words, part 0
// (digest bytes 0..7, first byte in bits 7..0) then part 1 with last_part
// set. The digest sits in its own output register, so new message bytes are
// accepted while it drains; a later finish waits until the previous digest
// is taken. The chain value and byte count return to their initial values
// after each finish. No clearing pass is needed after reset.
module md5_byte_stream_hasher_unit (
  input  logic                   clk,
  input  logic                   rst,
  md5bsh_byte_if.sink            msg,
  md5bsh_digest_if.source        digest
);
  import md5bsh_pkg::*;

  // Block buffer: 16 little-endian words, written one byte lane at a time.
  logic [31:0] block_mem [16];
  logic [31:0] rd_data;
  logic [3:0]  rd_addr;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;

  hash_state_t state, state_next;
  logic [63:0] count, count_next;
  logic [5:0]  pad_pos, pad_pos_next;
  logic        wrap, wrap_next;
  logic        second, second_next;
  logic        finishing, finishing_next;
  logic [6:0]  cnt, cnt_next;
  logic [31:0] a, b, c, d;
  logic [31:0] a_next, b_next, c_next, d_next;
  logic [31:0] chain [4];
  logic [31:0] chain_next [4];
  logic        out_valid, out_valid_next;
  logic        out_part, out_part_next;
  logic [63:0] dig_lo, dig_hi;
  logic        load_out;

  logic        msg_fire;
  logic        out_fire;
  logic [63:0] bit_len;
  logic [7:0]  pad_byte;
  logic        final_blk;
  logic [5:0]  rnd;

  assign msg.ready          = (state == ST_IDLE);
  assign msg_fire           = msg.valid & msg.ready;
  assign out_fire           = digest.valid & digest.ready;
  assign digest.valid       = out_valid;
  assign digest.part_index  = out_part;
  assign digest.last_part   = out_part;
  assign digest.digest_part = out_part ? dig_hi : dig_lo;

  assign bit_len   = {count[60:0], 3'b000};
  assign final_blk = !wrap || second;
  assign rnd       = cnt[5:0] - 6'd1;

  // Padding byte for the current pad position.
  always_comb begin
    if (!second && pad_pos == count[5:0]) begin
      pad_byte = PAD_MARK;
    end else if (final_blk && pad_pos >= LEN_FIRST_POS) begin
      pad_byte = bit_len[{pad_pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Buffer memory. The sequencer never reads and writes in the same state,
  // and the first round read comes in the cycle after the last byte write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      block_mem[wr_pos[5:2]][{wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= block_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      finishing <= 1'b0;
      out_valid <= 1'b0;
      out_part  <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= CHAIN_INIT[i];
      end
    end else begin
      state     <= state_next;
      count     <= count_next;
      finishing <= finishing_next;
      out_valid <= out_valid_next;
      out_part  <= out_part_next;
      for (int i = 0; i < 4; i++) begin
        chain[i] <= chain_next[i];
      end
    end
  end

  // Working registers and digest payload.
  always_ff @(posedge clk) begin
    pad_pos <= pad_pos_next;
    wrap    <= wrap_next;
    second  <= second_next;
    cnt     <= cnt_next;
    a       <= a_next;
    b       <= b_next;
    c       <= c_next;
    d       <= d_next;
    if (load_out) begin
      dig_lo <= {chain[1], chain[0]};
      dig_hi <= {chain[3], chain[2]};
    end
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    pad_pos_next   = pad_pos;
    wrap_next      = wrap;
    second_next    = second;
    finishing_next = finishing;
    cnt_next       = cnt;
    a_next         = a;
    b_next         = b;
    c_next         = c;
    d_next         = d;
    chain_next     = chain;
    out_valid_next = out_valid;
    out_part_next  = out_part;
    load_out       = 1'b0;
    wr_en          = 1'b0;
    wr_pos         = count[5:0];
    wr_byte        = msg.data_byte;
    rd_addr        = msg_index(cnt[5:0]);

    // Drain the digest: part 0, then part 1.
    if (out_fire) begin
      if (!out_part) begin
        out_part_next = 1'b1;
      end else begin
        out_valid_next = 1'b0;
      end
    end

    unique case (state)
      ST_IDLE: begin
        if (msg_fire) begin
          unique case (msg.command)
            CMD_ABSORB: begin
              wr_en      = 1'b1;
              count_next = count + 64'd1;
              if (count[5:0] == LAST_POS) begin
                cnt_next       = '0;
                finishing_next = 1'b0;
                a_next         = chain[0];
                b_next         = chain[1];
                c_next         = chain[2];
                d_next         = chain[3];
                state_next     = ST_COMP;
              end
            end
            CMD_FINISH: begin
              pad_pos_next   = count[5:0];
              wrap_next      = (count[5:0] >= LEN_FIRST_POS - 6'd1) &&
                               (count[5:0] != LEN_FIRST_POS - 6'd1);
              second_next    = 1'b0;
              finishing_next = 1'b1;
              state_next     = ST_PAD;
            end
            default: begin
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_PAD: begin
        wr_en        = 1'b1;
        wr_pos       = pad_pos;
        wr_byte      = pad_byte;
        pad_pos_next = pad_pos + 6'd1;
        if (pad_pos == LAST_POS) begin
          cnt_next   = '0;
          a_next     = chain[0];
          b_next     = chain[1];
          c_next     = chain[2];
          d_next     = chain[3];
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        // Read word for round cnt; rd_data holds the word for round cnt-1.
        if (cnt != '0) begin
          a_next = d;
          d_next = c;
          c_next = b;
          b_next = md5_round(a, b, c, d, rd_data, rnd);
        end
        cnt_next = cnt + 7'd1;
        if (cnt == ROUND_END) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        chain_next[0] = chain[0] + a;
        chain_next[1] = chain[1] + b;
        chain_next[2] = chain[2] + c;
        chain_next[3] = chain[3] + d;
        if (!finishing) begin
          state_next = ST_IDLE;
        end else if (wrap && !second) begin
          second_next  = 1'b1;
          pad_pos_next = '0;
          state_next   = ST_PAD;
        end else begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        // Hold until the previous digest has left.
        if (!out_valid) begin
          load_out       = 1'b1;
          out_valid_next = 1'b1;
          out_part_next  = 1'b0;
          finishing_next = 1'b0;
          count_next     = '0;
          chain_next     = CHAIN_INIT;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[hw/rtl/md5bsh_checker.sv]
// Port-level checks of the MD5 byte stream hasher digest channel.
// Depends on md5_byte_stream_hasher_unit_defines.svh; bound to the top level.
`include "md5_byte_stream_hasher_unit_defines.svh"

module md5bsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] digest_part,
  input logic        part_index,
  input logic        last_part
);

  `MD5BSH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(digest_part), "digest word dropped or changed while stalled")

  `MD5BSH_ASSERT_NOW(a_last_is_second, out_valid, last_part == part_index, "last_part must mark part 1 only")

  `MD5BSH_ASSERT_NEXT(a_part1_follows, out_valid && out_ready && !part_index, out_valid && part_index, "part 1 must follow part 0")

  `MD5BSH_ASSERT_NEXT(a_gap_after_last, out_valid && out_ready && last_part, !out_valid, "new digest right after last part")

endmodule

bind md5_byte_stream_hasher_unit md5bsh_checker u_md5bsh_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (digest.valid),
  .out_ready   (digest.ready),
  .digest_part (digest.digest_part),
  .part_index  (digest.part_index),
  .last_part   (digest.last_part)
);

[bench/tb.sv]
// Self-checking bench for md5_byte_stream_hasher_unit: byte and finish words
// in, digest words out. Needs md5bsh_pkg and the channel interfaces (md5bsh_if.sv).
module tb;
  import md5bsh_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 5;
  localparam int RANDOM_WORDS  = 1050;
  localparam int SETTLE_CYCLES = 250;     // room for the longest finish
  localparam int CYCLE_LIMIT   = 2000000;
  localparam int REPORT_MAX    = 10;

  localparam logic [7:0] MD5_PAD_MARK = 8'h80;

  // Rotation per round, indexed by stage * 4 + round mod 4.
  localparam int SHIFT_TAB [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Message lengths that put the finish at the padding corners: room for the
  // length in the same block, exactly no room, block-aligned ends.
  localparam int BOUNDARY_LENS [14] = '{
    0, 1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128
  };

  typedef struct packed {
    logic [63:0] part;
    logic        idx;
    logic        last;
  } digest_word_t;

  // One row of the directed table. Rows with pinned set carry the digest
  // that the finish must produce, known by heart for short messages.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  data;
    logic        pinned;
    logic [63:0] lo;
    logic [63:0] hi;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 15;

  localparam logic [63:0] EMPTY_LO = 64'h04b2008fd98c1dd4;
  localparam logic [63:0] EMPTY_HI = 64'h7e42f8ec980980e9;
  localparam logic [63:0] ABC_LO   = 64'hb04fd23c98500190;
  localparam logic [63:0] ABC_HI   = 64'h727fe1287d3f96d6;
  localparam logic [63:0] A_LO     = 64'ha8b6f1c0b975c10c;
  localparam logic [63:0] A_HI     = 64'h61267769e299c331;

  stim_row_t directed_tab [DIRECTED_ROWS] = '{
    // empty message right after reset
    '{CMD_FINISH, 8'h00, 1'b1, EMPTY_LO, EMPTY_HI},
    // empty again; the byte on a finish word must be ignored
    '{CMD_FINISH, 8'hff, 1'b1, EMPTY_LO, EMPTY_HI},
    '{CMD_ABSORB, 8'h61, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'h62, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'h63, 1'b0, 64'h0, 64'h0},
    '{CMD_FINISH, 8'h5a, 1'b1, ABC_LO, ABC_HI},
    '{CMD_ABSORB, 8'h61, 1'b0, 64'h0, 64'h0},
    '{CMD_FINISH, 8'ha5, 1'b1, A_LO, A_HI},
    // extreme byte values, checked against the predictor
    '{CMD_ABSORB, 8'h00, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'hff, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'h80, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'h7f, 1'b0, 64'h0, 64'h0},
    '{CMD_FINISH, 8'h00, 1'b0, 64'h0, 64'h0},
    '{CMD_ABSORB, 8'h00, 1'b0, 64'h0, 64'h0},
    '{CMD_FINISH, 8'hff, 1'b0, 64'h0, 64'h0}
  };

  logic clk;
  logic rst;

  md5bsh_byte_if   msg_if ();
  md5bsh_digest_if digest_if ();

  md5_byte_stream_hasher_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg_if.sink),
    .digest (digest_if.source)
  );

  // ---------------------------------------------------------------------------
  // MD5 predictor state: chain words, the 64-byte block and the byte count.
  // ---------------------------------------------------------------------------
  logic [31:0] sine_k [64];
  logic [31:0] chain [4];
  logic [7:0]  blk_bytes [64];
  logic [63:0] msg_len;

  digest_word_t pending_digest [$];
  int           mismatches;

  // Digest pinned by the directed table for the finish now on the bus.
  logic        pin_digest;
  logic [63:0] pin_lo;
  logic [63:0] pin_hi;

  // Sender pacing.
  int burst_left;

  // Receiver stall pattern.
  int rx_mode;
  int rx_left;

  function automatic void md5_restart();
    chain[0] = 32'h67452301;
    chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe;
    chain[3] = 32'h10325476;
    msg_len  = 64'd0;
  endfunction

  // Run the 64 rounds over blk_bytes and add the result into the chain.
  function automatic void md5_fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    int s;
    for (int i = 0; i < 16; i++)
      w[i] = {blk_bytes[4*i+3], blk_bytes[4*i+2], blk_bytes[4*i+1], blk_bytes[4*i]};
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (int i = 0; i < 64; i++) begin
      case (i / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      s = SHIFT_TAB[(i / 16) * 4 + i % 4];
      t = a + f + w[g] + sine_k[i];
      t = (t << s) | (t >> (32 - s));
      t = t + b;
      a = d;
      d = c;
      c = b;
      b = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
  endfunction

  // Advance the predictor by one accepted word; a finish queues two digest words.
  function automatic void md5_take_word(input logic cmd, input logic [7:0] data);
    int pos;
    logic [63:0] bits;
    digest_word_t lo_word;
    digest_word_t hi_word;
    pos = int'(msg_len[5:0]);
    if (cmd == CMD_ABSORB) begin
      blk_bytes[pos] = data;
      msg_len = msg_len + 64'd1;
      if (pos == 63) md5_fold_block();
    end else begin
      blk_bytes[pos] = MD5_PAD_MARK;
      pos = pos + 1;
      // no room left for the length: close this block, pad a second one
      if (pos > 56) begin
        while (pos < 64) begin
          blk_bytes[pos] = 8'h00;
          pos = pos + 1;
        end
        md5_fold_block();
        pos = 0;
      end
      while (pos < 56) begin
        blk_bytes[pos] = 8'h00;
        pos = pos + 1;
      end
      bits = msg_len << 3;
      for (int i = 0; i < 8; i++) blk_bytes[56 + i] = bits[8*i +: 8];
      md5_fold_block();
      lo_word = '{part: {chain[1], chain[0]}, idx: 1'b0, last: 1'b0};
      hi_word = '{part: {chain[3], chain[2]}, idx: 1'b1, last: 1'b1};
      if (pin_digest) begin
        lo_word.part = pin_lo;
        hi_word.part = pin_hi;
      end
      pending_digest.push_back(lo_word);
      pending_digest.push_back(hi_word);
      md5_restart();
    end
  endfunction

  // Compare one received digest word against the oldest one queued.
  function automatic void check_digest_word(input digest_word_t got);
    digest_word_t want;
    if (pending_digest.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("unexpected digest word: part=%h idx=%0d last=%0d",
                 got.part, got.idx, got.last);
    end else begin
      want = pending_digest.pop_front();
      if (got.part !== want.part || got.idx !== want.idx || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("digest word mismatch: expected part=%h idx=%0d last=%0d, got %h %0d %0d",
                   want.part, want.idx, want.last, got.part, got.idx, got.last);
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, reset, and the round constants derived from the sine table.
  // ---------------------------------------------------------------------------
  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  initial begin
    real r;
    for (int i = 0; i < 64; i++) begin
      r = $sin(real'(i + 1));
      if (r < 0.0) r = -r;
      sine_k[i] = 32'(longint'($floor(r * 4294967296.0)));
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge. Take the input word
  // first so that a finish is predicted before any digest word is checked.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_if.valid && msg_if.ready)
        md5_take_word(msg_if.command, msg_if.data_byte);
      if (digest_if.valid && digest_if.ready)
        check_digest_word('{part: digest_if.digest_part, idx: digest_if.part_index,
                            last: digest_if.last_part});
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch among always-ready, coin-flip, mostly-stalled and
  // toggling stretches so stalls land on both digest words and on idle time.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(10, 80);
    end
    rx_left = rx_left - 1;
    case (rx_mode)
      0: digest_if.ready <= 1'b1;
      1: digest_if.ready <= 1'($urandom_range(0, 1));
      2: digest_if.ready <= ($urandom_range(0, 7) == 0);
      default: digest_if.ready <= ~digest_if.ready;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sender. Words go out in bursts; between bursts hold valid low for a
  // random gap. Some bursts are long with no gap at all.
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic cmd, input logic [7:0] data);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(80, 250)
                                               : $urandom_range(1, 30);
      if (gap > 0) begin
        @(negedge clk);
        msg_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    msg_if.valid     <= 1'b1;
    msg_if.command   <= cmd;
    msg_if.data_byte <= data;
    @(posedge clk);
    while (!msg_if.ready) @(posedge clk);
    burst_left = burst_left - 1;
  endtask

  // Drop valid and hold off until every queued digest word has arrived.
  task automatic drain_digests();
    @(negedge clk);
    msg_if.valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // Watchdog: end the run if the stimulus or the drain hangs.
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL md5_byte_stream_hasher_unit");
    $finish;
  end

  initial begin
    int words_sent;
    int len;
    // Hold every input at a known value from time zero.
    rst                = 1'b1;
    msg_if.valid       = 1'b0;
    msg_if.command     = CMD_ABSORB;
    msg_if.data_byte   = 8'h00;
    digest_if.ready    = 1'b0;
    pin_digest         = 1'b0;
    pin_lo             = 64'h0;
    pin_hi             = 64'h0;
    mismatches         = 0;
    burst_left         = 0;
    rx_mode            = 0;
    rx_left            = 0;
    words_sent         = 0;
    md5_restart();
    for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table: the pin is updated with nonblocking writes, so the
    // monitor still sees the pin of the row accepted at the same edge.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      pin_digest <= directed_tab[i].pinned;
      pin_lo     <= directed_tab[i].lo;
      pin_hi     <= directed_tab[i].hi;
      send_word(directed_tab[i].cmd, directed_tab[i].data);
    end
    pin_digest <= 1'b0;
    drain_digests();

    // Random messages: mostly short, a quarter sized to hit the padding corners.
    while (words_sent < RANDOM_WORDS) begin
      if ($urandom_range(0, 3) == 0)
        len = BOUNDARY_LENS[$urandom_range(0, 13)];
      else
        len = $urandom_range(0, 70);
      for (int j = 0; j < len; j++) begin
        send_word(CMD_ABSORB, 8'($urandom_range(0, 255)));
        words_sent++;
      end
      send_word(CMD_FINISH, 8'($urandom_range(0, 255)));
      words_sent++;
      if ($urandom_range(0, 5) == 0) drain_digests();
    end

    // Wait out the queue, then give the block time to show any stray word.
    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_digest.size() == 0)
      $display("PASS md5_byte_stream_hasher_unit");
    else
      $display("FAIL md5_byte_stream_hasher_unit");
    $finish;
  end

endmodule
